// ===== design/fbs_pkg.sv =====
// Shared types and constants of the framed register bus slave.
`timescale 1ns / 1ps
package fbs_pkg;

   localparam int BYTE_W      = 8;
   localparam int IDX_W       = 6;
   localparam int NODE_W      = 7;
   localparam int CSR_IDX_W   = 3;
   localparam int RX_REGS_DEF = 16;
   localparam int TX_REGS_DEF = 16;

   typedef enum logic [1:0] {
      CMD_BUS_BYTE = 2'd0,
      CMD_TX_WRITE = 2'd1,
      CMD_RX_READ  = 2'd2,
      CMD_NONE     = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_ONE = 3'd0,
      CSR_START_TWO = 3'd1,
      CSR_NODE_ID   = 3'd2,
      CSR_REPLY_ONE = 3'd3,
      CSR_REPLY_TWO = 3'd4
   } csr_reg_type;

   localparam logic KIND_BUS   = 1'b0;
   localparam logic KIND_LOCAL = 1'b1;
   localparam logic DIR_WRITE  = 1'b0;

   typedef struct packed {
      cmd_type           cmd;
      logic [BYTE_W-1:0] data_byte;
      logic [IDX_W-1:0]  reg_index;
   } req_item_type;

   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] out_byte;
      logic              last;
   } rsp_item_type;

   typedef struct packed {
      logic stage_we;
      logic commit;
      logic rd_en;
   } rx_ctl_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } tx_ctl_type;

endpackage

// ===== design/fbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fbs_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/fbs_rx_bank.sv =====
// Received bank: staging and live halves in one RAM, swapped on frame commit.
`timescale 1ns / 1ps
module fbs_rx_bank #(
   parameter int  RX_REGS = fbs_pkg::RX_REGS_DEF,
   localparam int RX_AW   = (RX_REGS > 1) ? $clog2(RX_REGS) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  fbs_pkg::rx_ctl_type        ctl,
   input  logic [RX_AW-1:0]           wr_idx,
   input  logic [fbs_pkg::BYTE_W-1:0] wr_data,
   input  logic [fbs_pkg::IDX_W-1:0]  rd_idx,
   output logic [fbs_pkg::BYTE_W-1:0] rd_data
);
   import fbs_pkg::*;

   localparam int RAM_DEPTH = 2 * (1 << RX_AW);

   logic              sel_ff, sel_in;
   logic              loaded_ff, loaded_in;
   logic              rd_ok_ff, rd_ok_in;
   logic [RX_AW:0]    ram_wr_addr;
   logic [RX_AW:0]    ram_rd_addr;
   logic [BYTE_W-1:0] ram_q;

   // Staging goes to the idle half; reads see the live half.
   assign ram_wr_addr = {~sel_ff, wr_idx};
   assign ram_rd_addr = {sel_ff, rd_idx[RX_AW-1:0]};

   always_comb begin
      sel_in    = sel_ff;
      loaded_in = loaded_ff;
      rd_ok_in  = rd_ok_ff;
      if (ctl.commit) begin
         sel_in    = ~sel_ff;
         loaded_in = 1'b1;
      end
      if (ctl.rd_en) begin
         rd_ok_in = loaded_ff && (rd_idx < IDX_W'(RX_REGS));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff    <= 1'b0;
         loaded_ff <= 1'b0;
         rd_ok_ff  <= 1'b0;
      end else begin
         sel_ff    <= sel_in;
         loaded_ff <= loaded_in;
         rd_ok_ff  <= rd_ok_in;
      end
   end

   fbs_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctl.stage_we),
      .wr_addr (ram_wr_addr),
      .wr_data (wr_data),
      .rd_en   (ctl.rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_q)
   );

   assign rd_data = rd_ok_ff ? ram_q : '0;

endmodule

// ===== design/fbs_tx_bank.sv =====
// Transmit bank: RAM plus per-entry valid bits so unwritten entries read zero.
`timescale 1ns / 1ps
module fbs_tx_bank #(
   parameter int  TX_REGS = fbs_pkg::TX_REGS_DEF,
   localparam int TX_AW   = (TX_REGS > 1) ? $clog2(TX_REGS) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  fbs_pkg::tx_ctl_type        ctl,
   input  logic [fbs_pkg::IDX_W-1:0]  wr_idx,
   input  logic [fbs_pkg::BYTE_W-1:0] wr_data,
   input  logic [TX_AW-1:0]           rd_addr,
   output logic [fbs_pkg::BYTE_W-1:0] rd_data
);
   import fbs_pkg::*;

   logic [TX_REGS-1:0] vld_ff, vld_in;
   logic               rd_vld_ff, rd_vld_in;
   logic               wr_hit;
   logic [BYTE_W-1:0]  ram_q;

   // Drop writes beyond the bank.
   assign wr_hit = ctl.wr_en && (wr_idx < IDX_W'(TX_REGS));

   always_comb begin
      vld_in    = vld_ff;
      rd_vld_in = rd_vld_ff;
      if (wr_hit) begin
         vld_in[wr_idx[TX_AW-1:0]] = 1'b1;
      end
      if (ctl.rd_en) begin
         rd_vld_in = vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   fbs_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (TX_REGS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_hit),
      .wr_addr (wr_idx[TX_AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign rd_data = rd_vld_ff ? ram_q : '0;

endmodule

// ===== design/framed_register_bus_slave.sv =====
// Top level: frame hunter, reply sequencer, register banks and control registers.
`timescale 1ns / 1ps
// Local read: the result comes from the registered RAM read and is loaded into the output
// register once the output slot is free.
// Throughput: 1 item per cycle, except that a read request stalls the input until its
// 2 + TX_REGS reply bytes are loaded into the output register (one per cycle, set by the
// transmit RAM read port, longer under output stalls); a local read holds it in ST_LREAD.
// Reset: synchronous; clears frame state, control registers and bank valid flags, no sweep.
module framed_register_bus_slave #(
   parameter int  RX_REGS = fbs_pkg::RX_REGS_DEF,
   parameter int  TX_REGS = fbs_pkg::TX_REGS_DEF,
   localparam int RX_AW   = (RX_REGS > 1) ? $clog2(RX_REGS) : 1,
   localparam int TX_AW   = (TX_REGS > 1) ? $clog2(TX_REGS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   // item input
   input  logic                          req_valid,
   output logic                          req_stall,
   input  fbs_pkg::req_item_type         req_item,
   // result output
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output fbs_pkg::rsp_item_type         rsp_item,
   // control register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fbs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fbs_pkg::BYTE_W-1:0]    csr_data
);
   import fbs_pkg::*;

   // Bus frame phase.
   typedef enum logic [3:0] {
      PH_START1 = 4'b0001,
      PH_START2 = 4'b0010,
      PH_ADDR   = 4'b0100,
      PH_RECV   = 4'b1000
   } phase_type;

   // Sequencer: idle takes items, the rest drive the output register.
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_LREAD = 5'b00010,
      ST_HDR1  = 5'b00100,
      ST_HDR2  = 5'b01000,
      ST_DATA  = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [RX_AW-1:0]  rx_count_ff, rx_count_in;
   logic [TX_AW-1:0]  tx_count_ff, tx_count_in;

   logic [BYTE_W-1:0] start_one_ff, start_one_in;
   logic [BYTE_W-1:0] start_two_ff, start_two_in;
   logic [NODE_W-1:0] node_id_ff, node_id_in;
   logic [BYTE_W-1:0] reply_one_ff, reply_one_in;
   logic [BYTE_W-1:0] reply_two_ff, reply_two_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_item_ff, rsp_item_in;

   logic              req_acc;
   logic              slot_free;
   rx_ctl_type        rx_ctl;
   tx_ctl_type        tx_ctl;
   logic [TX_AW-1:0]  tx_rd_addr;
   logic [BYTE_W-1:0] rx_rd_data;
   logic [BYTE_W-1:0] tx_rd_data;
   logic              tx_last;

   // Take items only between results; a pending output never blocks a plain bus byte.
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign tx_last   = (tx_count_ff == TX_AW'(TX_REGS - 1));

   // Control register writes; unknown indexes drop.
   always_comb begin
      start_one_in = start_one_ff;
      start_two_in = start_two_ff;
      node_id_in   = node_id_ff;
      reply_one_in = reply_one_ff;
      reply_two_in = reply_two_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_START_ONE: start_one_in = csr_data;
            CSR_START_TWO: start_two_in = csr_data;
            CSR_NODE_ID:   node_id_in   = csr_data[NODE_W-1:0];
            CSR_REPLY_ONE: reply_one_in = csr_data;
            CSR_REPLY_TWO: reply_two_in = csr_data;
            default: ;
         endcase
      end
   end

   // Frame hunting, local access decode and reply sequencing.
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      rx_count_in  = rx_count_ff;
      tx_count_in  = tx_count_ff;
      rx_ctl       = '0;
      tx_ctl       = '0;
      tx_rd_addr   = tx_count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;

      // The consumer took the held item: free the output register.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               unique case (req_item.cmd)
                  CMD_BUS_BYTE: begin
                     unique case (phase_ff)
                        PH_START1: begin
                           if (req_item.data_byte == start_one_ff) begin
                              phase_in = PH_START2;
                           end
                        end
                        PH_START2: begin
                           // A mismatch restarts the hunt without rechecking this byte.
                           phase_in = (req_item.data_byte == start_two_ff) ? PH_ADDR
                                                                          : PH_START1;
                        end
                        PH_ADDR: begin
                           phase_in = PH_START1;
                           if (req_item.data_byte[BYTE_W-1:1] == node_id_ff) begin
                              if (req_item.data_byte[0] == DIR_WRITE) begin
                                 phase_in    = PH_RECV;
                                 rx_count_in = '0;
                              end else begin
                                 state_in = ST_HDR1;
                              end
                           end
                        end
                        PH_RECV: begin
                           // Stage into the idle half; swap halves on the final byte.
                           rx_ctl.stage_we = 1'b1;
                           if (rx_count_ff == RX_AW'(RX_REGS - 1)) begin
                              rx_ctl.commit = 1'b1;
                              rx_count_in   = '0;
                              phase_in      = PH_START1;
                           end else begin
                              rx_count_in = rx_count_ff + 1'b1;
                           end
                        end
                        default: phase_in = PH_START1;
                     endcase
                  end
                  CMD_TX_WRITE: begin
                     tx_ctl.wr_en = 1'b1;
                  end
                  CMD_RX_READ: begin
                     rx_ctl.rd_en = 1'b1;
                     state_in     = ST_LREAD;
                  end
                  default: ;
               endcase
            end
         end
         ST_LREAD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = '{kind: KIND_LOCAL, out_byte: rx_rd_data, last: 1'b1};
               state_in     = ST_IDLE;
            end
         end
         ST_HDR1: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = '{kind: KIND_BUS, out_byte: reply_one_ff, last: 1'b0};
               state_in     = ST_HDR2;
            end
         end
         ST_HDR2: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_item_in   = '{kind: KIND_BUS, out_byte: reply_two_ff, last: 1'b0};
               // Prefetch the first bank byte.
               tx_ctl.rd_en  = 1'b1;
               tx_rd_addr    = '0;
               tx_count_in   = '0;
               state_in      = ST_DATA;
            end
         end
         ST_DATA: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = '{kind: KIND_BUS, out_byte: tx_rd_data, last: tx_last};
               if (tx_last) begin
                  state_in = ST_IDLE;
               end else begin
                  // Advance and fetch the next byte while this one goes out.
                  tx_ctl.rd_en = 1'b1;
                  tx_rd_addr   = tx_count_ff + 1'b1;
                  tx_count_in  = tx_count_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_START1;
         rx_count_ff  <= '0;
         tx_count_ff  <= '0;
         start_one_ff <= '0;
         start_two_ff <= '0;
         node_id_ff   <= '0;
         reply_one_ff <= '0;
         reply_two_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rx_count_ff  <= rx_count_in;
         tx_count_ff  <= tx_count_in;
         start_one_ff <= start_one_in;
         start_two_ff <= start_two_in;
         node_id_ff   <= node_id_in;
         reply_one_ff <= reply_one_in;
         reply_two_ff <= reply_two_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload holds while stalled since it only loads into a free slot.
   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   fbs_rx_bank #(
      .RX_REGS (RX_REGS)
   ) u_rx_bank (
      .clock   (clock),
      .reset   (reset),
      .ctl     (rx_ctl),
      .wr_idx  (rx_count_ff),
      .wr_data (req_item.data_byte),
      .rd_idx  (req_item.reg_index),
      .rd_data (rx_rd_data)
   );

   fbs_tx_bank #(
      .TX_REGS (TX_REGS)
   ) u_tx_bank (
      .clock   (clock),
      .reset   (reset),
      .ctl     (tx_ctl),
      .wr_idx  (req_item.reg_index),
      .wr_data (req_item.data_byte),
      .rd_addr (tx_rd_addr),
      .rd_data (tx_rd_data)
   );

   // Replies are only sequenced after an address byte, which returns the hunt to start.
   a_reply_phase: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HDR2 || state_ff == ST_DATA) |-> phase_ff == PH_START1)
      else $error("reply in progress with frame phase not at first start");

   // The payload counter rests at zero outside payload reception.
   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_RECV |-> rx_count_ff == '0)
      else $error("payload count nonzero outside payload reception");

   // A non-final bus byte in the output register means the reply is still running.
   a_reply_open: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.kind == KIND_BUS && !rsp_item_ff.last)
      |-> (state_ff == ST_HDR2 || state_ff == ST_DATA))
      else $error("open reply byte without active reply sequence");

   // A local read result always closes its item.
   a_local_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.kind == KIND_LOCAL) |-> rsp_item_ff.last)
      else $error("local read result without last flag");

endmodule
